// ===== hw/rtl/lz77td_pkg.sv =====
// ----------------------------------------------------------------------------
// lz77td_pkg
// Shared constants, payload structs, command format and state types for the
// token decoder core.
// ----------------------------------------------------------------------------
package lz77td_pkg;

   localparam int HISTORY_DEPTH    = 65536;
   localparam int BYTES_PER_RESULT = 4;
   localparam int PACK_BYTES       = (BYTES_PER_RESULT > 4) ? 4 : BYTES_PER_RESULT;
   localparam int HIST_AW          = $clog2(HISTORY_DEPTH);
   localparam int PACK_CW          = $clog2(PACK_BYTES);
   localparam int PRODUCED_W       = 17;
   localparam int MAX_PRODUCED     = 65536;
   localparam int CMDQ_DEPTH       = 2;
   localparam int CMDQ_AW          = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CW          = $clog2(CMDQ_DEPTH + 1);

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_FLAG   = 2'd1;
   localparam logic [1:0] ST_BAD_OFFSET = 2'd2;
   localparam logic [1:0] ST_TRUNCATED  = 2'd3;

   localparam logic [7:0] FLAG_LITERAL = 8'h00;
   localparam logic [7:0] FLAG_MATCH   = 8'h01;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       stream_last;
   } req_type;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic [1:0]  status;
      logic        run_last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_LITERAL,
      CMD_COPY,
      CMD_ERROR
   } cmd_kind_type;

   // value is the literal byte or the copy length
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   value;
      logic [15:0]  offset;
      logic [1:0]   status;
      logic         last;
   } cmd_type;

   typedef enum logic [2:0] {
      FR_FLAG,
      FR_LITERAL,
      FR_OFF_LO,
      FR_OFF_HI,
      FR_LENGTH
   } front_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_COPY
   } back_state_type;

endpackage

// ===== hw/rtl/lz77_token_decoder_core.sv =====
// ----------------------------------------------------------------------------
// lz77_token_decoder_core
// Token stream decompressor: literal and match tokens in, packed bytes out.
// ----------------------------------------------------------------------------
// Flag, offset and literal bytes are taken one per cycle while the two-entry
// command queue has room; the parser never waits on the copy engine otherwise.
// The copy engine handles a literal, an error, an ignored end of stream or a
// zero-length match when it pops the command; a nonzero-length match is started,
// then its bytes are read and written one per cycle while the result register
// can take the packed words, a pace set by the single read and single write port
// of the 64 KiB history memory. A result is held in one output register, so the
// engine stalls only while that register is full and not being popped. The
// history memory is not cleared after reset; offset checks keep reads within bytes already written.
module lz77_token_decoder_core import lz77td_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic    cmd_push;
   cmd_type cmd_in_data;
   logic    cmd_full;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_out_data;

   lz77td_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in_data),
      .cmd_full (cmd_full)
   );

   lz77td_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .valid     (cmd_valid),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data)
   );

   lz77td_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_out_data),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   a_reset_empties : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result register not empty after reset");

   a_error_shape : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.status != ST_OK)) |->
         (rsp_data.byte_count == 3'd0) && (rsp_data.data_word == 32'd0) && rsp_data.run_last)
      else $error("error result carries data");

   a_ok_count : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.status == ST_OK)) |->
         (rsp_data.byte_count != 3'd0) && (rsp_data.byte_count <= 3'(PACK_BYTES)))
      else $error("ok result with bad byte count");

   a_cmd_pop_valid : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");

endmodule

// ===== hw/rtl/lz77td_front.sv =====
// ----------------------------------------------------------------------------
// lz77td_front
// Token parser: takes one stream byte per transfer, tracks the token phase,
// checks match offsets against the bytes produced and issues commands.
// ----------------------------------------------------------------------------
module lz77td_front import lz77td_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_push,
   output cmd_type cmd_data,
   input  logic    cmd_full
);

   front_state_type        state_ff, state_in;
   logic                   halted_ff, halted_in;
   logic [15:0]            offset_ff, offset_in;
   logic [PRODUCED_W-1:0]  produced_ff, produced_in;

   logic                   accept;
   logic                   is_flag;
   logic                   off_bad;
   logic [PRODUCED_W:0]    produced_sum;

   assign req_full = cmd_full;
   assign accept   = req_push && !cmd_full;
   assign is_flag  = (req_data.in_byte == FLAG_LITERAL) || (req_data.in_byte == FLAG_MATCH);

   assign off_bad = (offset_ff == 16'd0)
                 || ({1'b0, offset_ff} > produced_ff)
                 || ({1'b0, offset_ff} > PRODUCED_W'(HISTORY_DEPTH));

   assign produced_sum = {1'b0, produced_ff} + (PRODUCED_W + 1)'(req_data.in_byte);

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         if (halted_ff || req_data.stream_last) begin
            if (req_data.stream_last) begin
               state_in = FR_FLAG;
            end
         end else begin
            unique case (state_ff)
               FR_FLAG: begin
                  if (req_data.in_byte == FLAG_LITERAL) begin
                     state_in = FR_LITERAL;
                  end else if (req_data.in_byte == FLAG_MATCH) begin
                     state_in = FR_OFF_LO;
                  end
               end
               FR_LITERAL: state_in = FR_FLAG;
               FR_OFF_LO:  state_in = FR_OFF_HI;
               FR_OFF_HI:  state_in = FR_LENGTH;
               FR_LENGTH:  state_in = FR_FLAG;
               default:    state_in = FR_FLAG;
            endcase
         end
      end
   end

   always_comb begin
      cmd_push    = 1'b0;
      cmd_data    = '0;
      halted_in   = halted_ff;
      offset_in   = offset_ff;
      produced_in = produced_ff;
      if (accept) begin
         cmd_data.last = req_data.stream_last;
         if (halted_ff) begin
            // ignored bytes; only the end of stream gets through
            if (req_data.stream_last) begin
               cmd_push      = 1'b1;
               cmd_data.kind = CMD_NOP;
            end
         end else begin
            unique case (state_ff)
               FR_FLAG: begin
                  if (!is_flag) begin
                     cmd_push        = 1'b1;
                     cmd_data.kind   = CMD_ERROR;
                     cmd_data.status = ST_BAD_FLAG;
                     halted_in       = 1'b1;
                  end else if (req_data.stream_last) begin
                     cmd_push        = 1'b1;
                     cmd_data.kind   = CMD_ERROR;
                     cmd_data.status = ST_TRUNCATED;
                  end
               end
               FR_LITERAL: begin
                  cmd_push       = 1'b1;
                  cmd_data.kind  = CMD_LITERAL;
                  cmd_data.value = req_data.in_byte;
                  if (produced_ff != PRODUCED_W'(MAX_PRODUCED)) begin
                     produced_in = produced_ff + 1'b1;
                  end
               end
               FR_OFF_LO, FR_OFF_HI: begin
                  if (state_ff == FR_OFF_LO) begin
                     offset_in = {8'h00, req_data.in_byte};
                  end else begin
                     offset_in = {req_data.in_byte, offset_ff[7:0]};
                  end
                  if (req_data.stream_last) begin
                     cmd_push        = 1'b1;
                     cmd_data.kind   = CMD_ERROR;
                     cmd_data.status = ST_TRUNCATED;
                  end
               end
               FR_LENGTH: begin
                  cmd_push = 1'b1;
                  if (off_bad) begin
                     cmd_data.kind   = CMD_ERROR;
                     cmd_data.status = ST_BAD_OFFSET;
                     halted_in       = 1'b1;
                  end else begin
                     cmd_data.kind   = CMD_COPY;
                     cmd_data.value  = req_data.in_byte;
                     cmd_data.offset = offset_ff;
                     if (produced_sum > (PRODUCED_W + 1)'(MAX_PRODUCED)) begin
                        produced_in = PRODUCED_W'(MAX_PRODUCED);
                     end else begin
                        produced_in = produced_sum[PRODUCED_W-1:0];
                     end
                  end
               end
               default: begin
                  cmd_push = 1'b0;
               end
            endcase
         end
         if (req_data.stream_last) begin
            halted_in   = 1'b0;
            offset_in   = '0;
            produced_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FR_FLAG;
         halted_ff   <= 1'b0;
         offset_ff   <= '0;
         produced_ff <= '0;
      end else begin
         state_ff    <= state_in;
         halted_ff   <= halted_in;
         offset_ff   <= offset_in;
         produced_ff <= produced_in;
      end
   end

endmodule

// ===== hw/rtl/lz77td_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// lz77td_cmd_queue
// Short command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lz77td_cmd_queue import lz77td_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   output logic    valid,
   input  logic    pop,
   output cmd_type pop_data
);

   cmd_type              entry_ff [CMDQ_DEPTH];
   logic [CMDQ_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CW-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CMDQ_CW'(CMDQ_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/lz77td_back.sv =====
// ----------------------------------------------------------------------------
// lz77td_back
// Copy engine: runs literal, copy and error commands against the history
// memory, packs decoded bytes into result words and holds the result register.
// ----------------------------------------------------------------------------
module lz77td_back import lz77td_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic [7:0]          hist_mem [HISTORY_DEPTH];

   back_state_type      state_ff, state_in;
   logic [HIST_AW-1:0]  wp_ff, wp_in;
   logic [HIST_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [7:0]          rd_left_ff, rd_left_in;
   logic [7:0]          wr_left_ff, wr_left_in;
   logic                last_ff, last_in;
   logic                pend_ff, pend_in;
   logic [31:0]         word_ff, word_in;
   logic [PACK_CW-1:0]  cnt_ff, cnt_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff, out_data_in;

   logic [7:0]          rd_data_ff;
   logic                byp_ff;
   logic [7:0]          byp_data_ff;

   logic                out_can_push;
   logic                out_push;
   rsp_type             out_word;
   logic                mem_we;
   logic [7:0]          mem_wdata;
   logic [7:0]          copy_byte;
   logic                word_done;
   logic                consume;
   logic                issue;
   logic                head_needs_out;
   logic                copy_start;
   logic [31:0]         word_next;

   assign out_can_push   = !out_valid_ff || rsp_pop;
   assign copy_byte      = byp_ff ? byp_data_ff : rd_data_ff;
   assign word_done      = (cnt_ff == PACK_CW'(PACK_BYTES - 1)) || (wr_left_ff == 8'd1);
   assign consume        = (state_ff == BK_COPY) && pend_ff && (!word_done || out_can_push);
   assign issue          = (state_ff == BK_COPY) && (rd_left_ff != 8'd0)
                        && (!pend_ff || consume);
   assign head_needs_out = (cmd_data.kind == CMD_LITERAL) || (cmd_data.kind == CMD_ERROR);
   assign copy_start     = (cmd_data.kind == CMD_COPY) && (cmd_data.value != 8'd0);
   assign word_next      = word_ff | ({24'h000000, copy_byte} << {cnt_ff, 3'b000});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && copy_start) begin
               state_in = BK_COPY;
            end
         end
         BK_COPY: begin
            if (consume && (wr_left_ff == 8'd1)) begin
               state_in = BK_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      cmd_pop    = 1'b0;
      mem_we     = 1'b0;
      mem_wdata  = 8'h00;
      out_push   = 1'b0;
      out_word   = '0;
      wp_in      = wp_ff;
      rd_ptr_in  = rd_ptr_ff;
      rd_left_in = rd_left_ff;
      wr_left_in = wr_left_ff;
      last_in    = last_ff;
      pend_in    = pend_ff;
      word_in    = word_ff;
      cnt_in     = cnt_ff;
      unique case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid && (!head_needs_out || out_can_push);
            if (cmd_pop) begin
               unique case (cmd_data.kind)
                  CMD_LITERAL: begin
                     mem_we              = 1'b1;
                     mem_wdata           = cmd_data.value;
                     wp_in               = wp_ff + 1'b1;
                     out_push            = 1'b1;
                     out_word.data_word  = {24'h000000, cmd_data.value};
                     out_word.byte_count = 3'd1;
                     out_word.status     = ST_OK;
                     out_word.run_last   = 1'b1;
                  end
                  CMD_ERROR: begin
                     out_push          = 1'b1;
                     out_word.status   = cmd_data.status;
                     out_word.run_last = 1'b1;
                  end
                  CMD_COPY: begin
                     rd_ptr_in  = wp_ff - cmd_data.offset[HIST_AW-1:0];
                     rd_left_in = cmd_data.value;
                     wr_left_in = cmd_data.value;
                     last_in    = cmd_data.last;
                     pend_in    = 1'b0;
                     word_in    = '0;
                     cnt_in     = '0;
                  end
                  CMD_NOP: begin
                     out_push = 1'b0;
                  end
               endcase
               // end of stream restarts the history position once the copy is done
               if (cmd_data.last && !copy_start) begin
                  wp_in = '0;
               end
            end
         end
         BK_COPY: begin
            if (issue) begin
               rd_ptr_in  = rd_ptr_ff + 1'b1;
               rd_left_in = rd_left_ff - 1'b1;
            end
            pend_in = issue || (pend_ff && !consume);
            if (consume) begin
               mem_we     = 1'b1;
               mem_wdata  = copy_byte;
               wp_in      = wp_ff + 1'b1;
               wr_left_in = wr_left_ff - 1'b1;
               if (word_done) begin
                  out_push            = 1'b1;
                  out_word.data_word  = word_next;
                  out_word.byte_count = 3'(cnt_ff) + 3'd1;
                  out_word.status     = ST_OK;
                  out_word.run_last   = (wr_left_ff == 8'd1);
                  word_in             = '0;
                  cnt_in              = '0;
               end else begin
                  word_in = word_next;
                  cnt_in  = cnt_ff + 1'b1;
               end
               if ((wr_left_ff == 8'd1) && last_ff) begin
                  wp_in = '0;
               end
            end
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_push) begin
         out_valid_in = 1'b1;
         out_data_in  = out_word;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         wp_ff        <= '0;
         rd_left_ff   <= '0;
         wr_left_ff   <= '0;
         last_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rd_left_ff   <= rd_left_in;
         wr_left_ff   <= wr_left_in;
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      word_ff     <= word_in;
      out_data_ff <= out_data_in;
   end

   // history memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wp_ff] <= mem_wdata;
      end
   end

   // a read of the slot written in the same cycle takes the new byte
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff  <= hist_mem[rd_ptr_ff];
         byp_ff      <= mem_we && (wp_ff == rd_ptr_ff);
         byp_data_ff <= mem_wdata;
      end
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lz77_token_decoder_core. A short table of token
// streams comes first, then randomly built streams, mostly well formed with
// some broken ones. Every accepted byte goes through a decoder model kept here;
// each result transfer is compared with the oldest predicted word.
// ----------------------------------------------------------------------------
module testbench;
   import lz77td_pkg::*;

   localparam int RANDOM_ITEMS  = 120;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_REPORTS   = 10;
   // ~165 bytes, up to 64 transfers each, each behind a random pop gap
   localparam int CYCLE_LIMIT   = 3_000_000;

   typedef struct packed {
      req_type req;
      logic    fixed;
      rsp_type rsp;
   } stim_row_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   // decoder model state
   logic [7:0]            hist_mem [HISTORY_DEPTH];
   logic [HIST_AW-1:0]    wr_pos   = '0;
   logic [PRODUCED_W-1:0] produced = '0;
   front_state_type       phase    = FR_FLAG;
   logic [15:0]           off_hold = '0;
   logic                  stopped  = 1'b0;

   rsp_type step_words [$];
   rsp_type expected_words [$];

   int   failures     = 0;
   int   live_items   = 0;
   int   cycles       = 0;
   int   hold_left    = 0;
   int   pop_gap      = 0;
   int   hold_asks    = 0;
   int   hold_seen    = 0;
   logic steady       = 1'b0;

   stim_row_type dir_rows [28];

   lz77_token_decoder_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic void add_word(logic [31:0] word, logic [2:0] cnt, logic [1:0] st,
                                    logic last);
      rsp_type w;
      w = '{data_word: word, byte_count: cnt, status: st, run_last: last};
      step_words = {step_words, w};
   endfunction

   function automatic void keep_byte(logic [7:0] b);
      hist_mem[wr_pos] = b;
      wr_pos = wr_pos + 1'b1;
      if (produced < MAX_PRODUCED)
         produced = produced + 1'b1;
   endfunction

   function automatic void clear_parser();
      wr_pos   = '0;
      produced = '0;
      phase    = FR_FLAG;
      off_hold = '0;
      stopped  = 1'b0;
   endfunction

   // words produced by one accepted byte land in step_words
   function automatic void decode_byte(req_type r);
      logic [31:0]        word;
      int                 cnt;
      logic [7:0]         v;
      logic [HIST_AW-1:0] src;
      step_words.delete();
      if (stopped) begin
         if (r.stream_last)
            clear_parser();
         return;
      end
      case (phase)
         FR_FLAG: begin
            if (r.in_byte == FLAG_LITERAL) begin
               phase = FR_LITERAL;
            end else if (r.in_byte == FLAG_MATCH) begin
               phase = FR_OFF_LO;
            end else begin
               add_word('0, 3'd0, ST_BAD_FLAG, 1'b1);
               stopped = 1'b1;
            end
         end
         FR_LITERAL: begin
            keep_byte(r.in_byte);
            add_word({24'h0, r.in_byte}, 3'd1, ST_OK, 1'b1);
            phase = FR_FLAG;
         end
         FR_OFF_LO: begin
            off_hold = {8'h00, r.in_byte};
            phase    = FR_OFF_HI;
         end
         FR_OFF_HI: begin
            off_hold[15:8] = r.in_byte;
            phase          = FR_LENGTH;
         end
         default: begin
            phase = FR_FLAG;
            if (off_hold == 0 || off_hold > produced || 32'(off_hold) > HISTORY_DEPTH) begin
               add_word('0, 3'd0, ST_BAD_OFFSET, 1'b1);
               stopped = 1'b1;
            end else begin
               word = '0;
               cnt  = 0;
               // source trails the write pointer, so overlapping copies repeat
               for (int k = 0; k < r.in_byte; k++) begin
                  src = wr_pos - off_hold[HIST_AW-1:0];
                  v   = hist_mem[src];
                  keep_byte(v);
                  word[8*cnt +: 8] = v;
                  cnt++;
                  if (cnt == PACK_BYTES || k + 1 == r.in_byte) begin
                     add_word(word, 3'(cnt), ST_OK, k + 1 == r.in_byte);
                     word = '0;
                     cnt  = 0;
                  end
               end
            end
         end
      endcase
      if (r.stream_last) begin
         if (!stopped && phase != FR_FLAG)
            add_word('0, 3'd0, ST_TRUNCATED, 1'b1);
         clear_parser();
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic stim_row_type plain(logic [7:0] b, logic l);
      stim_row_type row;
      row = '0;
      row.req.in_byte     = b;
      row.req.stream_last = l;
      return row;
   endfunction

   // row whose single result is typed in
   function automatic stim_row_type checked(logic [7:0] b, logic l, logic [31:0] word,
                                            logic [2:0] cnt, logic [1:0] st);
      stim_row_type row;
      row = plain(b, l);
      row.fixed = 1'b1;
      row.rsp   = '{data_word: word, byte_count: cnt, status: st, run_last: 1'b1};
      return row;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 8'd0;
      else if (r < 75)
         return 8'($urandom_range(1, 8));
      else if (r < 95)
         return 8'($urandom_range(9, 40));
      return 8'($urandom_range(41, 255));
   endfunction

   task automatic send_row(stim_row_type row);
      int gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= row.req;
      @(posedge clock);
      while (req_full) @(posedge clock);
      // transfer taken at this edge
      if (!stopped)
         live_items++;
      decode_byte(row.req);
      if (row.fixed)
         expected_words = {expected_words, row.rsp};
      else
         expected_words = {expected_words, step_words};
   endtask

   task automatic send_byte(logic [7:0] b, logic l);
      send_row(plain(b, l));
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
   endtask

   task automatic send_stream();
      int          tokens;
      int          pick;
      int          made;
      logic        fin;
      logic [7:0]  len;
      logic [15:0] off;
      tokens = $urandom_range(1, 10);
      made   = 0;
      for (int t = 0; t < tokens; t++) begin
         fin  = (t == tokens - 1);
         pick = $urandom_range(0, 99);
         if (pick < 92 && (pick < 45 || made == 0)) begin
            send_byte(FLAG_LITERAL, 1'b0);
            send_byte(8'($urandom), fin);
            made++;
         end else if (pick < 92) begin
            off = 16'($urandom_range(1, (made > 65535) ? 65535 : made));
            len = pick_length();
            send_byte(FLAG_MATCH, 1'b0);
            send_byte(off[7:0], 1'b0);
            send_byte(off[15:8], 1'b0);
            send_byte(len, fin);
            made += len;
         end else if (pick < 96) begin
            // bad flag or bad offset, then bytes that must be ignored
            fin = ($urandom_range(0, 3) == 0);
            if (pick < 94) begin
               send_byte(8'($urandom_range(2, 255)), fin);
            end else begin
               off = ($urandom_range(0, 1) == 0 || made >= 65535) ?
                     16'h0 : 16'($urandom_range(made + 1, 65535));
               send_byte(FLAG_MATCH, 1'b0);
               send_byte(off[7:0], 1'b0);
               send_byte(off[15:8], 1'b0);
               send_byte(8'($urandom), fin);
            end
            if (!fin) begin
               repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
               send_byte(8'($urandom), 1'b1);
            end
            return;
         end else begin
            // token cut short by the end of the stream
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
               send_byte(FLAG_LITERAL, 1'b1);
            end else begin
               send_byte(FLAG_MATCH, pick == 1);
               if (pick > 1)
                  send_byte(8'($urandom), pick == 2);
               if (pick > 2)
                  send_byte(8'($urandom), 1'b1);
            end
            return;
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
         rsp_pop  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         if (!steady && $urandom_range(0, 5) == 0)
            pop_gap = pick_gap();
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected transfer: word=%h count=%0d status=%0d last=%0d",
                        rsp_data.data_word, rsp_data.byte_count, rsp_data.status,
                        rsp_data.run_last);
         end else begin
            want = expected_words.pop_front();
            if (rsp_data.data_word !== want.data_word ||
                rsp_data.byte_count !== want.byte_count ||
                rsp_data.status !== want.status ||
                rsp_data.run_last !== want.run_last) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $write("mismatch: expected word=%h count=%0d status=%0d last=%0d, ",
                         want.data_word, want.byte_count, want.status, want.run_last);
                  $display("got word=%h count=%0d status=%0d last=%0d",
                           rsp_data.data_word, rsp_data.byte_count, rsp_data.status,
                           rsp_data.run_last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      dir_rows = '{
         plain(FLAG_LITERAL, 1'b0),
         checked(8'hFF, 1'b0, 32'h0000_00FF, 3'd1, ST_OK),
         plain(FLAG_LITERAL, 1'b0),
         checked(8'h5A, 1'b0, 32'h0000_005A, 3'd1, ST_OK),
         // overlapping copy of the previous byte
         plain(FLAG_MATCH, 1'b0), plain(8'h01, 1'b0), plain(8'h00, 1'b0),
         plain(8'h09, 1'b0),
         // offset equal to bytes produced, longest length
         plain(FLAG_MATCH, 1'b0), plain(8'h0B, 1'b0), plain(8'h00, 1'b0),
         plain(8'hFF, 1'b0),
         // offset beyond bytes produced, then ignored bytes until end of stream
         plain(FLAG_MATCH, 1'b0), plain(8'hFF, 1'b0), plain(8'hFF, 1'b0),
         checked(8'h00, 1'b0, 32'h0, 3'd0, ST_BAD_OFFSET),
         plain(8'h42, 1'b0),
         plain(8'h00, 1'b1),
         // stream ends on the offset high byte
         plain(FLAG_MATCH, 1'b0), plain(8'h00, 1'b0),
         checked(8'h00, 1'b1, 32'h0, 3'd0, ST_TRUNCATED),
         // zero offset on the final byte
         plain(FLAG_MATCH, 1'b0), plain(8'h00, 1'b0), plain(8'h00, 1'b0),
         checked(8'h03, 1'b1, 32'h0, 3'd0, ST_BAD_OFFSET),
         checked(8'h7F, 1'b0, 32'h0, 3'd0, ST_BAD_FLAG),
         plain(8'h00, 1'b1),
         // literal flag on the final byte
         checked(FLAG_LITERAL, 1'b1, 32'h0, 3'd0, ST_TRUNCATED)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_row(dir_rows[i]);
      wait_drained();

      live_items = 0;
      while (live_items < RANDOM_ITEMS / 2) begin
         steady = ($urandom_range(0, 4) == 0);
         send_stream();
      end
      steady = 1'b0;

      // receiver holds off while long copies back up the input side
      hold_asks++;
      send_byte(FLAG_LITERAL, 1'b0);
      send_byte(8'($urandom), 1'b0);
      repeat (3) begin
         send_byte(FLAG_MATCH, 1'b0);
         send_byte(8'h01, 1'b0);
         send_byte(8'h00, 1'b0);
         send_byte(8'hFF, 1'b0);
      end
      send_byte(FLAG_LITERAL, 1'b0);
      send_byte(8'($urandom), 1'b1);
      wait_drained();

      while (live_items < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         send_stream();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
